/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file prq_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication that must hold on every clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

/* src/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ID_WIDTH      = 6;
   localparam int PRIO_WIDTH    = 8;
   localparam int OCC_WIDTH     = 5;
   localparam int STATUS_WIDTH  = 2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                  cmd;
      logic [ID_WIDTH-1:0]   item_id;
      logic [PRIO_WIDTH-1:0] item_priority;
   } req_type;

   typedef struct packed {
      logic                    out_valid;
      logic [ID_WIDTH-1:0]     out_id;
      logic [PRIO_WIDTH-1:0]   out_priority;
      logic [STATUS_WIDTH-1:0] status;
      logic [OCC_WIDTH-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   id;
      logic [PRIO_WIDTH-1:0] prio;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ENQ_SCAN,
      S_DEQ_READ,
      S_FINISH
   } state_type;

endpackage

/* src/priority_ready_queue.sv */
// A request is taken in S_IDLE. Full, empty and insert into an empty queue go
// straight to S_FINISH; a dequeue reads the head in S_DEQ_READ first, and any
// other insert scans in S_ENQ_SCAN. One request at a time; an insert
// scans from the tail one RAM slot per cycle, bound by the single RAM read port.
// The next request is taken while the response waits in the output register.
// Reset (synchronous) empties the queue; RAM contents are left as they are.
// ----------------------------------------------------------------------------
// priority_ready_queue
// Scheduler ready queue sorted by priority, first-in first-out among equals.
// ----------------------------------------------------------------------------
module priority_ready_queue #(
   parameter int DEPTH = prq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  prq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prq_pkg::rsp_type rsp_data
);
   import prq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [ENTRY_WIDTH-1:0] rd_data;
   logic                   res_valid;
   logic                   res_ready;
   rsp_type                res_data;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   prq_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   prq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // output register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/prq_ram.sv */
// ----------------------------------------------------------------------------
// prq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/prq_ctrl.sv */
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer of the sorted queue: circular buffer in RAM, insertion by a
// tail-to-head scan that shifts entries up one slot per cycle.
// ----------------------------------------------------------------------------
module prq_ctrl #(
   parameter int DEPTH = prq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  prq_pkg::req_type         req_data,
   output logic                     res_valid,
   input  logic                     res_ready,
   output prq_pkg::rsp_type         res_data,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [prq_pkg::ENTRY_WIDTH-1:0] wr_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [prq_pkg::ENTRY_WIDTH-1:0] rd_data
);
   import prq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type      state_ff, state_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pos_ff, pos_in;
   entry_type      ent_ff, ent_in;
   rsp_type        res_ff, res_in;
   entry_type      rd_entry;
   entry_type      req_entry;

   // logical slot -> physical address, head-relative with wrap
   function automatic logic [AW-1:0] phys(input logic [CW-1:0] slot,
                                         input logic [AW-1:0] head);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(slot);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign rd_entry  = entry_type'(rd_data);
   assign req_entry = '{id: req_data.item_id, prio: req_data.item_priority};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      ent_ff <= ent_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      ent_in    = ent_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = phys(pos_ff, head_ff);
      wr_data   = ent_ff;
      rd_en     = 1'b0;
      rd_addr   = phys(pos_ff - CW'(2), head_ff);
      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ent_in = req_entry;
               res_in = '0;
               res_in.occupancy = OCC_WIDTH'(count_ff);
               if (req_data.cmd == CMD_ENQUEUE) begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_in.status = STATUS_FULL;
                     state_in      = S_FINISH;
                  end else if (count_ff == '0) begin
                     wr_en            = 1'b1;
                     wr_addr          = head_ff;
                     wr_data          = req_entry;
                     count_in         = CW'(1);
                     res_in.occupancy = OCC_WIDTH'(1);
                     state_in         = S_FINISH;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = phys(count_ff - CW'(1), head_ff);
                     pos_in   = count_ff;
                     state_in = S_ENQ_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_EMPTY;
                     state_in      = S_FINISH;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = S_DEQ_READ;
                  end
               end
            end
         end
         S_ENQ_SCAN: begin
            // rd_entry holds slot pos-1; equal priority stops the scan
            wr_en = 1'b1;
            if (pos_ff == '0 || rd_entry.prio >= ent_ff.prio) begin
               wr_data          = ent_ff;
               count_in         = count_ff + CW'(1);
               res_in.occupancy = OCC_WIDTH'(count_ff + CW'(1));
               state_in         = S_FINISH;
            end else begin
               wr_data = rd_entry;
               pos_in  = pos_ff - CW'(1);
               rd_en   = (pos_ff > CW'(1));
            end
         end
         S_DEQ_READ: begin
            res_in.out_valid    = 1'b1;
            res_in.out_id       = rd_entry.id;
            res_in.out_priority = rd_entry.prio;
            res_in.status       = STATUS_OK;
            count_in            = count_ff - CW'(1);
            res_in.occupancy    = OCC_WIDTH'(count_ff - CW'(1));
            head_in             = phys(CW'(1), head_ff);
            state_in            = S_FINISH;
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

endmodule

/* src/prq_checker.sv */
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks of the priority ready queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prq_checker #(
   parameter int DEPTH = prq_pkg::DEPTH_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input prq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input prq_pkg::rsp_type rsp_data
);
   import prq_pkg::*;

   logic req_stall;
   logic req_take;
   logic rsp_stall;
   logic rsp_error;
   logic rsp_full;
   logic rsp_no_entry;

   assign req_stall    = req_valid && !req_ready;
   assign req_take     = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_error    = rsp_valid && rsp_data.status != STATUS_OK;
   assign rsp_full     = rsp_valid && rsp_data.status == STATUS_FULL;
   assign rsp_no_entry = !rsp_data.out_valid && rsp_data.out_id == '0 &&
                         rsp_data.out_priority == '0;

   `ASSERT_IMPLY(a_req_hold, clock, reset, req_stall, ##1 (req_valid && $stable(req_data)))
   `ASSERT_IMPLY(a_rsp_hold, clock, reset, rsp_stall, ##1 (rsp_valid && $stable(rsp_data)))
   `ASSERT_IMPLY(a_one_at_a_time, clock, reset, req_take, ##1 !req_ready)
   `ASSERT_IMPLY(a_no_entry_on_error, clock, reset, rsp_error, rsp_no_entry)
   `ASSERT_IMPLY(a_full_occupancy, clock, reset, rsp_full, rsp_data.occupancy == OCC_WIDTH'(DEPTH))

endmodule

bind priority_ready_queue prq_checker #(.DEPTH(DEPTH)) u_prq_checker (.*);

/* bench/tb_priority_ready_queue.sv */
// ----------------------------------------------------------------------------
// tb_priority_ready_queue
// Drives enqueue and dequeue requests into the ready queue, with the sender
// working in bursts and the receiver stalling, and checks every response
// against an in-bench sorted queue that keeps FIFO order among equal
// priorities.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue;

   timeunit 1ns;
   timeprecision 1ps;

   import prq_pkg::*;

   localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int TAIL_CYCLES  = 3 * (QUEUE_DEPTH + 3);
   localparam int MAX_PRINTS   = 40;

   // Tracks queue contents and the responses still owed by the block.
   class ready_queue_tracker;
      entry_type held_entries[$];
      rsp_type   awaited_responses[$];
      int        mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      function int outstanding();
         return awaited_responses.size();
      endfunction

      task report_mismatch(string msg);
         if (mismatch_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      // Sorted insert: a new entry goes behind every entry of equal or
      // higher priority.
      function void note_request(req_type r);
         rsp_type   owed;
         entry_type slot;
         int        pos;
         owed = '0;
         if (r.cmd == CMD_ENQUEUE) begin
            if (held_entries.size() >= QUEUE_DEPTH) begin
               owed.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < held_entries.size() &&
                      held_entries[pos].prio >= r.item_priority)
                  pos++;
               slot.id   = r.item_id;
               slot.prio = r.item_priority;
               held_entries.insert(pos, slot);
               owed.status = STATUS_OK;
            end
         end else if (held_entries.size() == 0) begin
            owed.status = STATUS_EMPTY;
         end else begin
            slot              = held_entries.pop_front();
            owed.out_valid    = 1'b1;
            owed.out_id       = slot.id;
            owed.out_priority = slot.prio;
            owed.status       = STATUS_OK;
         end
         owed.occupancy = OCC_WIDTH'(held_entries.size());
         awaited_responses.push_back(owed);
      endfunction

      task check_response(rsp_type got);
         rsp_type owed;
         if (awaited_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", got));
         end else begin
            owed = awaited_responses.pop_front();
            if (got !== owed)
               report_mismatch($sformatf(
                  "valid %b/%b id %0d/%0d prio %0d/%0d status %0d/%0d occ %0d/%0d",
                  got.out_valid, owed.out_valid, got.out_id, owed.out_id,
                  got.out_priority, owed.out_priority, got.status, owed.status,
                  got.occupancy, owed.occupancy));
         end
      endtask
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   ready_queue_tracker queue_tracker;
   int                 cycle_count = 0;
   int                 burst_left  = 0;
   logic [7:0]         stall_pattern;
   int                 pattern_life;

   priority_ready_queue #(.DEPTH(QUEUE_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            queue_tracker.note_request(req_data);
         if (rsp_valid && rsp_ready)
            queue_tracker.check_response(rsp_data);
      end
   end

   // Receiver stalls follow a rotating pattern, replaced every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         stall_pattern <= 8'hff;
         pattern_life  <= 0;
      end else begin
         rsp_ready <= stall_pattern[0];
         if (pattern_life == 0) begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
            pattern_life  <= $urandom_range(20, 120);
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
            pattern_life  <= pattern_life - 1;
         end
      end
   end

   function automatic req_type build_request(logic cmd, int id, int prio);
      req_type r;
      r.cmd           = cmd;
      r.item_id       = ID_WIDTH'(id);
      r.item_priority = PRIO_WIDTH'(prio);
      return r;
   endfunction

   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) begin
            req_data <= build_request(1'($urandom_range(0, 1)), $urandom, $urandom);
            @(posedge clock);
         end
      end
   endtask

   // One request, then a gap (possibly empty) whenever the current burst runs out.
   task automatic issue(logic cmd, int id, int prio);
      send_request(build_request(cmd, id, prio));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
   endtask

   task automatic wait_for_drain();
      idle_cycles(1);
      while (queue_tracker.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int enq_percent;
      int seg_left;
      int tie_prio;
      int prio;

      queue_tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dequeue, fill with ties and extremes, full drop, drain a few
      issue(CMD_DEQUEUE, 0, 0);
      issue(CMD_ENQUEUE, 5, 100);
      issue(CMD_ENQUEUE, 63, 255);
      issue(CMD_ENQUEUE, 0, 0);
      issue(CMD_ENQUEUE, 7, 100);
      issue(CMD_ENQUEUE, 9, 100);
      issue(CMD_ENQUEUE, 1, 255);
      issue(CMD_ENQUEUE, 42, 128);
      issue(CMD_ENQUEUE, 21, 127);
      issue(CMD_ENQUEUE, 10, 0);
      issue(CMD_ENQUEUE, 11, 1);
      issue(CMD_ENQUEUE, 12, 254);
      issue(CMD_ENQUEUE, 13, 100);
      issue(CMD_ENQUEUE, 14, 200);
      issue(CMD_ENQUEUE, 15, 200);
      issue(CMD_ENQUEUE, 16, 64);
      issue(CMD_ENQUEUE, 17, 32);
      issue(CMD_ENQUEUE, 50, 255);
      repeat (4) issue(CMD_DEQUEUE, 0, 0);
      wait_for_drain();

      // random: segments biased to fill, drain or hover so full and empty recur
      seg_left = 0;
      enq_percent = 50;
      tie_prio = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(15, 45);
            case ($urandom_range(0, 2))
               0: enq_percent = 85;
               1: enq_percent = 15;
               default: enq_percent = 55;
            endcase
            tie_prio = $urandom_range(0, 255);
         end
         seg_left--;
         case ($urandom_range(0, 3))
            0: prio = tie_prio;
            1: prio = ($urandom_range(0, 1) == 0) ? 0 : 255;
            default: prio = $urandom_range(0, 255);
         endcase
         issue(($urandom_range(1, 100) <= enq_percent) ? CMD_ENQUEUE : CMD_DEQUEUE,
               $urandom_range(0, 63), prio);
         if (n == RANDOM_ITEMS / 2)
            wait_for_drain();
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (queue_tracker.mismatch_count == 0 && queue_tracker.outstanding() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* priority_ready_queue.f */
+incdir+src
src/prq_pkg.sv
src/prq_ram.sv
src/prq_ctrl.sv
src/priority_ready_queue.sv
src/prq_checker.sv
bench/tb_priority_ready_queue.sv
